>>> design/frca_pkg.sv
// ----------------------------------------------------------------------------
// frca_pkg
// Shared types, constants and helpers of the resource credit allocator.
// ----------------------------------------------------------------------------
package frca_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int CLIENT_SLOTS_DEF = 16;
  localparam int POOL_COUNT_DEF   = 3;

  localparam int ResW    = 2;
  localparam int JobW    = 16;
  localparam int ClientW = 4;
  localparam int AmtW    = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int EntryW  = ClientW + JobW + AmtW;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic KIND_GRANT  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CPU_CAP = 2'd0,
    CFG_MEM_CAP = 2'd1,
    CFG_GPU_CAP = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REJ,
    S_REL_RD,
    S_REL_ADD,
    S_DRAIN,
    S_CHK,
    S_GUPD,
    S_EMIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic latch;
    logic ins;
    logic rej_push;
    logic pool_clr;
    logic pool_next;
    logic rel_rd;
    logic rel_add;
    logic hold_clr;
    logic st_rd;
    logic grant;
    logic gupd;
    logic emit;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic is_rel;
    logic full;
    logic holds_in;
    logic fill_zero;
    logic fits;
    logic last_pool;
    logic out_free;
    logic pend_valid;
  } sts_t;

  function automatic logic [AmtW-1:0] sat16(input logic [AmtW-1:0] a,
                                            input logic [AmtW-1:0] b);
    logic [AmtW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AmtW] ? {AmtW{1'b1}} : s[AmtW-1:0];
  endfunction

endpackage

>>> design/frca_if.sv
// ----------------------------------------------------------------------------
// frca_if
// Request, result and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface frca_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  resource;
  logic [15:0] job_id;
  logic [3:0]  client;
  logic [15:0] amount;
  modport source(output valid, command, resource, job_id, client, amount, input ready);
  modport sink(input valid, command, resource, job_id, client, amount, output ready);
endinterface

interface frca_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] grant_job;
  logic [3:0]  grant_client;
  logic [1:0]  grant_resource;
  logic [15:0] grant_amount;
  logic        last_result;
  modport source(output valid, result_kind, grant_job, grant_client, grant_resource,
                 grant_amount, last_result, input ready);
  modport sink(input valid, result_kind, grant_job, grant_client, grant_resource,
               grant_amount, last_result, output ready);
endinterface

interface frca_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/fifo_resource_credit_allocator.sv
// ----------------------------------------------------------------------------
// fifo_resource_credit_allocator
// Head-of-line FIFO allocator for cpu, mem and gpu credit pools.
//
//   channel  dir  contents
//   in_i     in   command, resource, job_id, client, amount
//   out_o    out  result_kind, grant_job, grant_client, grant_resource,
//                 grant_amount, last_result
//   cfg_i    in   index (pool capacity register), data
//
// One item at a time. Decode latches and checks the request. Draining visits
// each pool in turn up to a head that blocks; each grant reads the request store,
// checks and grants, updates the client total RAM and emits. A release first
// reads and adds back the client's total in each pool. No clearing pass after
// reset. A stalled output stretches the drain; the input is taken again once
// the final result, if any, is in the output register.
// ----------------------------------------------------------------------------
module fifo_resource_credit_allocator #(
  parameter int QueueDepth  = frca_pkg::QUEUE_DEPTH_DEF,
  parameter int ClientSlots = frca_pkg::CLIENT_SLOTS_DEF,
  parameter int PoolCount   = frca_pkg::POOL_COUNT_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  frca_req_if.sink   in_i,
  frca_res_if.source out_o,
  frca_cfg_if.sink   cfg_i
);
  import frca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  frca_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  frca_dp #(
    .QueueDepth (QueueDepth),
    .ClientSlots(ClientSlots),
    .PoolCount  (PoolCount)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_command_i  (in_i.command),
    .in_resource_i (in_i.resource),
    .in_job_i      (in_i.job_id),
    .in_client_i   (in_i.client),
    .in_amount_i   (in_i.amount),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_kind_o    (out_o.result_kind),
    .out_job_o     (out_o.grant_job),
    .out_client_o  (out_o.grant_client),
    .out_resource_o(out_o.grant_resource),
    .out_amount_o  (out_o.grant_amount),
    .out_last_o    (out_o.last_result)
  );
endmodule

>>> design/frca_ram.sv
// ----------------------------------------------------------------------------
// frca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> design/frca_ctrl.sv
// ----------------------------------------------------------------------------
// frca_ctrl
// Sequencer: decode, reject, release and in-order drain of each pool.
// ----------------------------------------------------------------------------
module frca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  frca_pkg::sts_t sts_i,
  output frca_pkg::cmd_t cmd_o
);
  import frca_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.pool_clr = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_rel) begin
          state_d = sts_i.holds_in ? S_REL_RD : S_IDLE;
        end else if (sts_i.full) begin
          state_d = S_REJ;
        end else begin
          cmd_o.ins = 1'b1;
          state_d   = S_DRAIN;
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.rej_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_REL_RD: begin
        cmd_o.rel_rd = 1'b1;
        state_d      = S_REL_ADD;
      end
      S_REL_ADD: begin
        cmd_o.rel_add = 1'b1;
        if (sts_i.last_pool) begin
          cmd_o.hold_clr = 1'b1;
          cmd_o.pool_clr = 1'b1;
          state_d        = S_DRAIN;
        end else begin
          cmd_o.pool_next = 1'b1;
          state_d         = S_REL_RD;
        end
      end
      S_DRAIN: begin
        if (sts_i.fill_zero) begin
          if (sts_i.last_pool) begin
            state_d = S_FIN;
          end else begin
            cmd_o.pool_next = 1'b1;
          end
        end else begin
          cmd_o.st_rd = 1'b1;
          state_d     = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.fits) begin
          cmd_o.grant = 1'b1;
          state_d     = S_GUPD;
        end else if (sts_i.last_pool) begin
          state_d = S_FIN;
        end else begin
          cmd_o.pool_next = 1'b1;
          state_d         = S_DRAIN;
        end
      end
      S_GUPD: begin
        cmd_o.gupd = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_DRAIN;
        end
      end
      S_FIN: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> design/frca_dp.sv
// ----------------------------------------------------------------------------
// frca_dp
// Datapath: pool queues, available counts, client totals and result stage.
// ----------------------------------------------------------------------------
module frca_dp #(
  parameter int QueueDepth  = frca_pkg::QUEUE_DEPTH_DEF,
  parameter int ClientSlots = frca_pkg::CLIENT_SLOTS_DEF,
  parameter int PoolCount   = frca_pkg::POOL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frca_pkg::cmd_t                cmd_i,
  output frca_pkg::sts_t                sts_o,
  input  logic                          in_command_i,
  input  logic [frca_pkg::ResW-1:0]     in_resource_i,
  input  logic [frca_pkg::JobW-1:0]     in_job_i,
  input  logic [frca_pkg::ClientW-1:0]  in_client_i,
  input  logic [frca_pkg::AmtW-1:0]     in_amount_i,
  input  logic                          cfg_we_i,
  input  logic [frca_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [frca_pkg::CfgW-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [frca_pkg::JobW-1:0]     out_job_o,
  output logic [frca_pkg::ClientW-1:0]  out_client_o,
  output logic [frca_pkg::ResW-1:0]     out_resource_o,
  output logic [frca_pkg::AmtW-1:0]     out_amount_o,
  output logic                          out_last_o
);
  import frca_pkg::*;

  localparam int QW  = $clog2(QueueDepth);
  localparam int FW  = $clog2(QueueDepth + 1);
  localparam int PW  = (PoolCount > 1) ? $clog2(PoolCount) : 1;
  localparam int SW  = $clog2(ClientSlots);
  localparam int SD  = PoolCount * QueueDepth;
  localparam int SAW = $clog2(SD);
  localparam int GD  = ClientSlots * PoolCount;
  localparam int GAW = $clog2(GD);

  function automatic logic [SW-1:0] slot_of(input logic [ClientW-1:0] c);
    logic [8:0] v;
    v = 9'(c);
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(ClientSlots)) v = v - 9'(ClientSlots);
    end
    return SW'(v);
  endfunction

  logic                cmd_q;
  logic [PW-1:0]       pool_q;
  logic [JobW-1:0]     job_q;
  logic [ClientW-1:0]  client_q;
  logic [AmtW-1:0]     amt_q;
  logic [PW-1:0]       dp_q;
  logic [QW-1:0]       head_q  [PoolCount];
  logic [FW-1:0]       fill_q  [PoolCount];
  logic [AmtW-1:0]     avail_q [PoolCount];
  logic [ClientSlots-1:0] holds_q;
  logic [GD-1:0]       gv_q;
  logic                gvalid_q;

  logic                pend_valid_q;
  logic [JobW-1:0]     pend_job_q;
  logic [ClientW-1:0]  pend_client_q;
  logic [PW-1:0]       pend_pool_q;
  logic [AmtW-1:0]     pend_amt_q;

  logic                out_valid_q;
  logic                out_kind_q;
  logic [JobW-1:0]     out_job_q;
  logic [ClientW-1:0]  out_client_q;
  logic [ResW-1:0]     out_res_q;
  logic [AmtW-1:0]     out_amt_q;
  logic                out_last_q;

  logic [EntryW-1:0]   st_rdata;
  logic [ClientW-1:0]  st_client;
  logic [JobW-1:0]     st_job;
  logic [AmtW-1:0]     st_amt;
  logic [QW:0]         tsum;
  logic [QW-1:0]       tail;
  logic [SAW-1:0]      st_waddr, st_raddr;
  logic [SW-1:0]       slot_in, slot_st, g_slot;
  logic [GAW-1:0]      g_addr;
  logic [AmtW-1:0]     g_rdata, g_val, g_wdata;
  logic [PW-1:0]       pool_in;
  logic                out_free;

  assign {st_client, st_job, st_amt} = st_rdata;
  assign slot_in = slot_of(client_q);
  assign slot_st = slot_of(st_client);
  assign g_slot  = cmd_i.rel_rd ? slot_in : slot_st;
  assign g_addr  = GAW'(32'(g_slot) * PoolCount + 32'(dp_q));
  // unwritten or released totals read as zero
  assign g_val   = gvalid_q ? g_rdata : '0;
  assign g_wdata = sat16(g_val, st_amt);

  always_comb begin
    tsum = {1'b0, head_q[pool_q]} + (QW+1)'(fill_q[pool_q]);
    if (tsum >= (QW+1)'(QueueDepth)) tsum = tsum - (QW+1)'(QueueDepth);
    tail = tsum[QW-1:0];
  end

  assign st_waddr = SAW'(32'(pool_q) * QueueDepth + 32'(tail));
  assign st_raddr = SAW'(32'(dp_q) * QueueDepth + 32'(head_q[dp_q]));
  assign pool_in  = (32'(in_resource_i) < PoolCount) ? PW'(in_resource_i) : PW'(PoolCount - 1);
  assign out_free = !out_valid_q || out_ready_i;

  frca_ram #(.Width(EntryW), .Depth(SD)) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ins),
    .waddr_i(st_waddr),
    .wdata_i({client_q, job_q, amt_q}),
    .re_i   (cmd_i.st_rd),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  frca_ram #(.Width(AmtW), .Depth(GD)) u_granted (
    .clk_i  (clk_i),
    .we_i   (cmd_i.gupd),
    .waddr_i(g_addr),
    .wdata_i(g_wdata),
    .re_i   (cmd_i.rel_rd || cmd_i.grant),
    .raddr_i(g_addr),
    .rdata_o(g_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q    <= in_command_i;
      pool_q   <= pool_in;
      job_q    <= in_job_i;
      client_q <= in_client_i;
      amt_q    <= in_amount_i;
    end
    if (cmd_i.emit) begin
      pend_job_q    <= st_job;
      pend_client_q <= st_client;
      pend_pool_q   <= dp_q;
      pend_amt_q    <= st_amt;
    end
    if (cmd_i.rej_push) begin
      out_kind_q   <= KIND_REJECT;
      out_job_q    <= job_q;
      out_client_q <= client_q;
      out_res_q    <= ResW'(pool_q);
      out_amt_q    <= amt_q;
      out_last_q   <= 1'b1;
    end else if ((cmd_i.emit || cmd_i.fin) && pend_valid_q) begin
      out_kind_q   <= KIND_GRANT;
      out_job_q    <= pend_job_q;
      out_client_q <= pend_client_q;
      out_res_q    <= ResW'(pend_pool_q);
      out_amt_q    <= pend_amt_q;
      out_last_q   <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q         <= '0;
      holds_q      <= '0;
      gv_q         <= '0;
      gvalid_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int p = 0; p < PoolCount; p++) begin
        head_q[p]  <= '0;
        fill_q[p]  <= '0;
        avail_q[p] <= '0;
      end
    end else begin
      if (cmd_i.pool_clr) begin
        dp_q <= '0;
      end else if (cmd_i.pool_next) begin
        dp_q <= dp_q + 1'b1;
      end
      if (cfg_we_i && cfg_index_i <= CFG_GPU_CAP && 32'(cfg_index_i) < PoolCount) begin
        avail_q[PW'(cfg_index_i)] <= cfg_data_i;
      end
      if (cmd_i.ins) begin
        fill_q[pool_q] <= fill_q[pool_q] + 1'b1;
      end
      if (cmd_i.rel_rd || cmd_i.grant) begin
        gvalid_q <= gv_q[g_addr];
      end
      if (cmd_i.rel_rd) begin
        gv_q[g_addr] <= 1'b0;
      end
      if (cmd_i.rel_add) begin
        avail_q[dp_q] <= sat16(avail_q[dp_q], g_val);
      end
      if (cmd_i.hold_clr) begin
        holds_q[slot_in] <= 1'b0;
      end
      if (cmd_i.grant) begin
        avail_q[dp_q] <= avail_q[dp_q] - st_amt;
        head_q[dp_q]  <= (head_q[dp_q] == QW'(QueueDepth - 1)) ? '0 : head_q[dp_q] + 1'b1;
        fill_q[dp_q]  <= fill_q[dp_q] - 1'b1;
      end
      if (cmd_i.gupd) begin
        holds_q[slot_st] <= 1'b1;
        gv_q[g_addr]     <= 1'b1;
      end
      if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.fin) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.rej_push || ((cmd_i.emit || cmd_i.fin) && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_rel     = (cmd_q == CMD_RELEASE);
  assign sts_o.full       = (fill_q[pool_q] == FW'(QueueDepth));
  assign sts_o.holds_in   = holds_q[slot_in];
  assign sts_o.fill_zero  = (fill_q[dp_q] == '0);
  assign sts_o.fits       = (avail_q[dp_q] >= st_amt);
  assign sts_o.last_pool  = (dp_q == PW'(PoolCount - 1));
  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_valid_q;

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_job_o      = out_job_q;
  assign out_client_o   = out_client_q;
  assign out_resource_o = out_res_q;
  assign out_amount_o   = out_amt_q;
  assign out_last_o     = out_last_q;
endmodule

>>> design/frca_checker.sv
// ----------------------------------------------------------------------------
// frca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module frca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic        out_last_i,
  input logic [15:0] out_job_i
);
  import frca_pkg::*;

  a_in_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while an item is in work");

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_REJECT |-> out_last_i)
    else $error("reject transfer not marked last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_job_i) && $stable(out_last_i))
    else $error("result changed while stalled");
endmodule

bind fifo_resource_credit_allocator frca_checker u_frca_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_kind_i (out_o.result_kind),
  .out_last_i (out_o.last_result),
  .out_job_i  (out_o.grant_job)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the head-of-line resource credit allocator. Drives
// reserve and release transfers with random gaps, stalls the result channel,
// predicts every grant and reject and compares them in order, field by field.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic        kind;
  logic [15:0] job;
  logic [3:0]  client;
  logic [1:0]  pool;
  logic [15:0] amount;
  logic        last;
} grant_t;

class alloc_scoreboard;
  logic [15:0] q_job[3][16];
  logic [3:0]  q_client[3][16];
  logic [15:0] q_amt[3][16];
  int          head[3];
  int          fill[3];
  logic [15:0] avail[3];
  logic [15:0] held[16][3];
  bit          holds[16];
  grant_t      pending[$];
  int          errors;

  function new();
    for (int p = 0; p < 3; p++) begin
      avail[p] = '0;
      head[p]  = 0;
      fill[p]  = 0;
      for (int c = 0; c < 16; c++) held[c][p] = '0;
    end
    errors = 0;
  endfunction

  function automatic logic [15:0] sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function void set_capacity(int p, logic [15:0] v);
    avail[p] = v;
  endfunction

  function int pool_fill(int p);
    return fill[p];
  endfunction

  function void drain();
    int          i;
    grant_t      g;
    for (int p = 0; p < 3; p++) begin
      while (fill[p] > 0) begin
        i = head[p];
        if (avail[p] < q_amt[p][i]) break;
        avail[p] -= q_amt[p][i];
        held[q_client[p][i]][p] = sat(held[q_client[p][i]][p], q_amt[p][i]);
        holds[q_client[p][i]] = 1;
        g = '{frca_pkg::KIND_GRANT, q_job[p][i], q_client[p][i], p[1:0], q_amt[p][i], 1'b0};
        pending.push_back(g);
        head[p] = (head[p] + 1) % 16;
        fill[p]--;
      end
    end
  endfunction

  function void note_request(logic cmd, logic [1:0] res, logic [15:0] job,
                             logic [3:0] cl, logic [15:0] amt);
    int     p;
    int     n0;
    int     i;
    grant_t g;
    n0 = pending.size();
    if (cmd == frca_pkg::CMD_RESERVE) begin
      p = (res > 2) ? 2 : res;
      if (fill[p] >= 16) begin
        g = '{frca_pkg::KIND_REJECT, job, cl, p[1:0], amt, 1'b1};
        pending.push_back(g);
        return;
      end
      i = (head[p] + fill[p]) % 16;
      q_job[p][i] = job; q_client[p][i] = cl; q_amt[p][i] = amt;
      fill[p]++;
    end else begin
      if (!holds[cl]) return;
      for (p = 0; p < 3; p++) begin
        avail[p] = sat(avail[p], held[cl][p]);
        held[cl][p] = 0;
      end
      holds[cl] = 0;
    end
    drain();
    if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
  endfunction

  function void check_result(grant_t got);
    grant_t e;
    if (pending.size() == 0) begin
      $error("unexpected result job %0d", got.job);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.kind !== got.kind) begin $error("result_kind exp %0d got %0d", e.kind, got.kind); errors++; end
    if (e.job !== got.job) begin $error("grant_job exp %0d got %0d", e.job, got.job); errors++; end
    if (e.client !== got.client) begin $error("grant_client exp %0d got %0d", e.client, got.client); errors++; end
    if (e.pool !== got.pool) begin $error("grant_resource exp %0d got %0d", e.pool, got.pool); errors++; end
    if (e.amount !== got.amount) begin $error("grant_amount exp %0d got %0d", e.amount, got.amount); errors++; end
    if (e.last !== got.last) begin $error("last_result exp %0d got %0d", e.last, got.last); errors++; end
  endfunction
endclass

module tb;
  import frca_pkg::*;

  logic clk_i;
  logic rst_ni;
  frca_req_if req();
  frca_res_if res();
  frca_cfg_if cfg();
  alloc_scoreboard sb;
  bit out_busy;

  fifo_resource_credit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req.sink), .out_o(res.source), .cfg_i(cfg.sink)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && res.valid && res.ready) begin
      g = '{res.result_kind, res.grant_job, res.grant_client, res.grant_resource,
            res.grant_amount, res.last_result};
      sb.check_result(g);
    end
  end

  initial begin
    int w;
    res.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      w = out_busy ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        res.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic write_cap(cfg_idx_e idx, logic [15:0] v);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    sb.set_capacity(int'(idx), v);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(logic cmd, logic [1:0] rs, logic [15:0] job,
                      logic [3:0] cl, logic [15:0] amt);
    int w;
    w = $urandom_range(0, 5);
    repeat (w) @(posedge clk_i);
    req.valid <= 1'b1; req.command <= cmd; req.resource <= rs;
    req.job_id <= job; req.client <= cl; req.amount <= amt;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(cmd, rs, job, cl, amt);
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    int t;
    t = 0;
    while (sb.pending.size() != 0 && t < 200000) begin @(posedge clk_i); t++; end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic phase(int n, logic [15:0] cmax);
    logic [15:0] amt;
    logic        cmd;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(0, 3) == 0);
      amt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, cmax));
      send(cmd, 2'($urandom), 16'($urandom), 4'($urandom), amt);
    end
  endtask

  initial begin
    sb = new();
    out_busy = 0;
    req.valid = 0; req.command = 0; req.resource = 0; req.job_id = 0;
    req.client = 0; req.amount = 0;
    cfg.valid = 0; cfg.index = CFG_CPU_CAP; cfg.data = 0;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // zero capacity: queue fills up, then rejects
    for (int k = 0; k < 17; k++) send(CMD_RESERVE, 2'd3, 16'(k), 4'(k), 16'hFFFF);
    send(CMD_RESERVE, 2'd0, 16'h0000, 4'd15, 16'd0);
    send(CMD_RELEASE, 2'd0, 16'h1234, 4'd3, 16'd0);
    send(CMD_RELEASE, 2'd0, 16'h1234, 4'd15, 16'd0);
    settle();
    write_cap(CFG_CPU_CAP, 16'hFFFF);
    write_cap(CFG_MEM_CAP, 16'd100);
    write_cap(CFG_GPU_CAP, 16'hFFFF);
    send(CMD_RESERVE, 2'd1, 16'hFFFF, 4'd15, 16'd60);
    send(CMD_RESERVE, 2'd1, 16'h0001, 4'd1, 16'd60);
    send(CMD_RESERVE, 2'd0, 16'h0002, 4'd0, 16'hFFFF);
    send(CMD_RELEASE, 2'd2, 16'h0003, 4'd15, 16'hFFFF);
    send(CMD_RELEASE, 2'd0, 16'h0004, 4'd0, 16'd0);
    settle();

    write_cap(CFG_CPU_CAP, 16'd500);
    write_cap(CFG_MEM_CAP, 16'd300);
    write_cap(CFG_GPU_CAP, 16'd0);
    phase(120, 16'd120);
    settle();
    write_cap(CFG_CPU_CAP, 16'd0);
    write_cap(CFG_MEM_CAP, 16'hFFFF);
    write_cap(CFG_GPU_CAP, 16'd2000);
    phase(120, 16'd400);
    settle();
    write_cap(CFG_CPU_CAP, 16'd50);
    write_cap(CFG_MEM_CAP, 16'd50);
    write_cap(CFG_GPU_CAP, 16'd50);
    phase(110, 16'd30);
    out_busy = 1;
    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
